// ===== hw/rtl/amod_pkg.sv =====
// ============================================================================
// amod_pkg
// Shared types and constants of the accelerometer motion and orientation
// detector: configuration set, event codes, axis codes and queue entry.
// ============================================================================
`default_nettype none

package amod_pkg;

    // Slots and fixed-point format of the filter.
    localparam int SLOT_COUNT  = 4;
    localparam int SLOT_W      = 2;
    localparam int FRAC_BITS   = 16;
    localparam int FILT_W      = 32;
    localparam int INT_W       = FILT_W - FRAC_BITS;
    localparam int ONE         = 1 << FRAC_BITS;
    localparam int COEF        = ONE / 10;
    localparam int COEF_W      = FRAC_BITS + 2;
    localparam int PROD_W      = FILT_W + COEF_W;
    localparam logic signed [COEF_W-1:0] COEF_S = COEF_W'(COEF);
    localparam logic signed [COEF_W-1:0] KEEP_S = COEF_W'(ONE - COEF);

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Channel and register port widths.
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 64;
    localparam int ADDR_W   = 5;

    // Register indexes.
    typedef enum logic [2:0] {
        REG_MOVE_THR     = 3'd0,
        REG_START_COUNT  = 3'd1,
        REG_STOP_COUNT   = 3'd2,
        REG_STABLE_COUNT = 3'd3,
        REG_STREAM_EN    = 3'd4,
        REG_STREAM_SLOT  = 3'd5
    } reg_index_t;

    // Event kinds carried on the result channel.
    typedef enum logic [1:0] {
        EV_MOVED   = 2'd0,
        EV_STOPPED = 2'd1,
        EV_UPAXIS  = 2'd2,
        EV_STREAM  = 2'd3
    } event_kind_t;

    // Axis direction codes.
    localparam logic [2:0] AXIS_UNKNOWN = 3'd0;
    localparam logic [2:0] DIR_POS [3] = '{3'd3, 3'd6, 3'd1};
    localparam logic [2:0] DIR_NEG [3] = '{3'd4, 3'd5, 3'd2};

    // Configuration registers as seen by the front.
    typedef struct packed {
        logic [7:0]        move_thr;
        logic [7:0]        start_count;
        logic [7:0]        stop_count;
        logic [7:0]        stable_count;
        logic              stream_en;
        logic [SLOT_W-1:0] stream_slot;
    } cfg_t;

    // Which results one sample causes, in delivery priority order.
    typedef struct packed {
        logic upaxis;
        logic moved;
        logic stopped;
        logic stream;
    } ev_mask_t;

    // One queue entry: everything the back needs to emit a sample's results.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [31:0]       stamp;
        logic [2:0]        dir;
        logic [2:0]        up_axis;
        logic [8:0]        rep_x;
        logic [8:0]        rep_y;
        logic [7:0]        rep_z;
        ev_mask_t          mask;
    } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/amod_queue.sv =====
// ============================================================================
// amod_queue
// Short first-in first-out queue of pending result jobs between the front
// and the back.
// ============================================================================
`default_nettype none

module amod_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  amod_pkg::job_t     push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output amod_pkg::job_t     head_job
);

    amod_pkg::job_t               mem [amod_pkg::QUEUE_DEPTH];
    logic [amod_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [amod_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [amod_pkg::QPTR_W:0]    count_reg, count_next;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + (push ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (pop ? 1'b1 : 1'b0);
        count_next  = count_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    assign full       = (count_reg == (amod_pkg::QPTR_W+1)'(amod_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== hw/rtl/amod_front.sv =====
// ============================================================================
// amod_front
// Accepts samples, updates the per-slot filter, motion counter and up-axis
// debounce over two stages, and queues the set of results each sample causes.
// ============================================================================
`default_nettype none

module amod_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  amod_pkg::cfg_t                     cfg,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [amod_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          q_full,
    output logic                               push,
    output amod_pkg::job_t                     push_job
);

    // Per-slot state.
    logic signed [amod_pkg::FILT_W-1:0] filt_reg [amod_pkg::SLOT_COUNT][3];
    logic [7:0] mcount_reg   [amod_pkg::SLOT_COUNT];
    logic       moving_reg   [amod_pkg::SLOT_COUNT];
    logic [2:0] last_dir_reg [amod_pkg::SLOT_COUNT];
    logic [2:0] rep_up_reg   [amod_pkg::SLOT_COUNT];
    logic [2:0] cand_up_reg  [amod_pkg::SLOT_COUNT];
    logic [7:0] cand_cnt_reg [amod_pkg::SLOT_COUNT];

    // Second stage registers.
    logic                                busy_reg;
    logic [amod_pkg::SLOT_W-1:0]         b_slot_reg;
    logic [31:0]                         b_stamp_reg;
    logic signed [7:0]                   b_a_reg [3];
    logic [7:0]                          b_mc1_reg;
    logic                                b_skip_reg;
    logic signed [amod_pkg::PROD_W-1:0]  b_keep_reg [3];
    logic signed [amod_pkg::FILT_W-1:0]  b_in_reg [3];

    // First stage signals.
    logic                                accept;
    logic [amod_pkg::SLOT_W-1:0]         in_slot;
    logic signed [7:0]                   in_a [3];
    logic signed [amod_pkg::FILT_W-1:0]  filt_a [3];
    logic signed [amod_pkg::FILT_W-1:0]  sh_a [3];
    logic signed [17:0]                  diff_a [3];
    logic [17:0]                         dabs_a [3];
    logic                                now_a;
    logic                                skip_a;
    logic [7:0]                          mc_a;
    logic                                mov_a;
    logic [7:0]                          mc1_a;
    logic signed [amod_pkg::PROD_W-1:0]  keep_a [3];
    logic signed [amod_pkg::FILT_W-1:0]  in_prod_a [3];

    // Second stage signals.
    logic signed [amod_pkg::FILT_W-1:0]  nf_b [3];
    logic signed [amod_pkg::FILT_W-1:0]  nsh_b [3];
    logic signed [amod_pkg::INT_W-1:0]   v_b [3];
    logic [amod_pkg::INT_W:0]            m_b [3];
    logic [amod_pkg::INT_W:0]            maxmag_b;
    logic [2:0]                          dir_b;
    logic                                changed_b;
    logic [2:0]                          cand_b;
    logic [2:0]                          rep_b;
    logic [7:0]                          ccnt_b;
    logic [7:0]                          mc_b;
    logic                                mov_b;
    amod_pkg::ev_mask_t                  mask_b;

    assign s_tready = !busy_reg && !q_full;
    assign accept   = s_tvalid && s_tready;

    // Unpack the sample and read its slot state.
    always_comb begin
        in_slot = s_tdata[1:0];
        in_a[0] = s_tdata[9:2];
        in_a[1] = s_tdata[17:10];
        in_a[2] = s_tdata[25:18];
        mc_a    = mcount_reg[in_slot];
        mov_a   = moving_reg[in_slot];
        now_a   = 1'b0;
        for (int k = 0; k < 3; k++) begin
            filt_a[k]    = filt_reg[in_slot][k];
            sh_a[k]      = filt_a[k] >>> amod_pkg::FRAC_BITS;
            diff_a[k]    = 18'(signed'(sh_a[k][amod_pkg::INT_W-1:0])) - 18'(in_a[k]);
            dabs_a[k]    = diff_a[k][17] ? 18'(-diff_a[k]) : 18'(diff_a[k]);
            if (dabs_a[k] >= 18'(cfg.move_thr)) begin
                now_a = 1'b1;
            end
            keep_a[k]    = filt_a[k] * amod_pkg::KEEP_S;
            in_prod_a[k] = in_a[k] * amod_pkg::COEF_S;
        end
    end

    // Motion counter hysteresis and filter hold.
    always_comb begin
        skip_a = 1'b0;
        mc1_a  = mc_a;
        if (now_a) begin
            skip_a = !mov_a && (mc_a <= 8'd1);
            if ((!mov_a || (mc_a < cfg.stop_count)) && (mc_a != 8'hFF)) begin
                mc1_a = mc_a + 8'd1;
            end
        end else if (mc_a != 8'd0) begin
            mc1_a = mc_a - 8'd1;
        end
    end

    // First to second stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_slot_reg  <= in_slot;
            b_stamp_reg <= s_tdata[57:26];
            b_mc1_reg   <= mc1_a;
            b_skip_reg  <= skip_a;
            for (int k = 0; k < 3; k++) begin
                b_a_reg[k]    <= in_a[k];
                b_keep_reg[k] <= keep_a[k];
                b_in_reg[k]   <= in_prod_a[k];
            end
        end
    end

    // New filter value and dominant axis.
    always_comb begin
        maxmag_b = '0;
        dir_b    = amod_pkg::AXIS_UNKNOWN;
        for (int k = 0; k < 3; k++) begin
            nf_b[k]  = b_skip_reg ? filt_reg[b_slot_reg][k]
                     : b_in_reg[k] + amod_pkg::FILT_W'(b_keep_reg[k] >>> amod_pkg::FRAC_BITS);
            nsh_b[k] = nf_b[k] >>> amod_pkg::FRAC_BITS;
            v_b[k]   = nsh_b[k][amod_pkg::INT_W-1:0];
            m_b[k]   = v_b[k][amod_pkg::INT_W-1] ? (amod_pkg::INT_W+1)'(-v_b[k])
                                                 : (amod_pkg::INT_W+1)'(v_b[k]);
            if (m_b[k] > maxmag_b) begin
                maxmag_b = m_b[k];
                dir_b    = (v_b[k] > 0) ? amod_pkg::DIR_POS[k] : amod_pkg::DIR_NEG[k];
            end
        end
    end

    // Up-axis debounce and motion events.
    always_comb begin
        changed_b = (last_dir_reg[b_slot_reg] != amod_pkg::AXIS_UNKNOWN)
                 && (last_dir_reg[b_slot_reg] != dir_b);
        cand_b    = cand_up_reg[b_slot_reg];
        rep_b     = rep_up_reg[b_slot_reg];
        ccnt_b    = cand_cnt_reg[b_slot_reg];
        mc_b      = b_mc1_reg;
        mov_b     = moving_reg[b_slot_reg];
        mask_b    = '0;
        if (dir_b == cand_b) begin
            if (cand_b != rep_b) begin
                if (ccnt_b != 8'hFF) begin
                    ccnt_b = ccnt_b + 8'd1;
                end
                if (ccnt_b >= cfg.stable_count) begin
                    mask_b.upaxis = 1'b1;
                    rep_b         = cand_b;
                end
            end else begin
                ccnt_b = 8'd0;
            end
        end else begin
            ccnt_b = 8'd0;
            cand_b = dir_b;
        end
        if (changed_b || ((b_mc1_reg >= cfg.start_count) && !mov_b)) begin
            mask_b.moved = 1'b1;
            mov_b        = 1'b1;
            mc_b         = cfg.stop_count;
        end else if ((b_mc1_reg == 8'd0) && mov_b) begin
            if (cand_b != rep_b) begin
                mask_b.upaxis = 1'b1;
                rep_b         = cand_b;
            end
            mask_b.stopped = 1'b1;
            mov_b          = 1'b0;
        end
        mask_b.stream = cfg.stream_en && (cfg.stream_slot == b_slot_reg);
    end

    // Queue entry for the back.
    always_comb begin
        push_job.slot    = b_slot_reg;
        push_job.stamp   = b_stamp_reg;
        push_job.dir     = dir_b;
        push_job.up_axis = cand_b;
        push_job.rep_x   = 9'(-(9'(b_a_reg[2])));
        push_job.rep_y   = 9'(-(9'(b_a_reg[0])));
        push_job.rep_z   = b_a_reg[1];
        push_job.mask    = mask_b;
        push             = busy_reg && (mask_b != '0);
    end

    // Slot state write back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < amod_pkg::SLOT_COUNT; i++) begin
                for (int k = 0; k < 3; k++) begin
                    filt_reg[i][k] <= '0;
                end
                mcount_reg[i]   <= '0;
                moving_reg[i]   <= 1'b0;
                last_dir_reg[i] <= amod_pkg::AXIS_UNKNOWN;
                rep_up_reg[i]   <= amod_pkg::AXIS_UNKNOWN;
                cand_up_reg[i]  <= amod_pkg::AXIS_UNKNOWN;
                cand_cnt_reg[i] <= '0;
            end
        end else if (busy_reg) begin
            for (int k = 0; k < 3; k++) begin
                filt_reg[b_slot_reg][k] <= nf_b[k];
            end
            mcount_reg[b_slot_reg]   <= mc_b;
            moving_reg[b_slot_reg]   <= mov_b;
            last_dir_reg[b_slot_reg] <= dir_b;
            rep_up_reg[b_slot_reg]   <= rep_b;
            cand_up_reg[b_slot_reg]  <= cand_b;
            cand_cnt_reg[b_slot_reg] <= ccnt_b;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/amod_back.sv =====
// ============================================================================
// amod_back
// Takes queued jobs and, while the receiver is ready, delivers their results
// one per cycle through an output register, marking the last of each sample.
// ============================================================================
`default_nettype none

module amod_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    input  amod_pkg::job_t                     q_job,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [amod_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast
);

    logic                              work_valid_reg;
    amod_pkg::job_t                    work_reg;
    amod_pkg::ev_mask_t                mask_reg, mask_next;
    amod_pkg::ev_mask_t                first;
    logic                              last;
    logic                              advance;
    logic                              out_valid_reg;
    logic [amod_pkg::M_DATA_W-1:0]     out_data_reg;
    amod_pkg::event_kind_t             out_kind_reg;
    logic                              out_last_reg;
    amod_pkg::event_kind_t             kind;
    logic [2:0]                        axis;
    logic [8:0]                        rx;
    logic [8:0]                        ry;
    logic [7:0]                        rz;

    // Pick the next result of the current job.
    always_comb begin
        first = '0;
        kind  = amod_pkg::EV_STREAM;
        axis  = amod_pkg::AXIS_UNKNOWN;
        rx    = work_reg.rep_x;
        ry    = work_reg.rep_y;
        rz    = work_reg.rep_z;
        priority if (mask_reg.upaxis) begin
            first.upaxis = 1'b1;
            kind         = amod_pkg::EV_UPAXIS;
            axis         = work_reg.up_axis;
            rx           = '0;
            ry           = '0;
            rz           = '0;
        end else if (mask_reg.moved) begin
            first.moved = 1'b1;
            kind        = amod_pkg::EV_MOVED;
            axis        = work_reg.dir;
        end else if (mask_reg.stopped) begin
            first.stopped = 1'b1;
            kind          = amod_pkg::EV_STOPPED;
            rx            = '0;
            ry            = '0;
            rz            = '0;
        end else begin
            first.stream = 1'b1;
        end
        mask_next = mask_reg & ~first;
        last      = (mask_next == '0);
    end

    assign advance = work_valid_reg && (!out_valid_reg || m_tready);
    assign q_pop   = q_valid && (!work_valid_reg || (advance && last));

    // Current job.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
        end else if (q_pop) begin
            work_valid_reg <= 1'b1;
        end else if (advance && last) begin
            work_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            work_reg <= q_job;
            mask_reg <= q_job.mask;
        end else if (advance) begin
            mask_reg <= mask_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {1'b0, rz, ry, rx, axis, work_reg.stamp, work_reg.slot};
            out_kind_reg <= kind;
            out_last_reg <= last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/accel_motion_and_orientation_detector_unit.sv =====
// ============================================================================
// accel_motion_and_orientation_detector_unit
// Per-slot accelerometer motion and up-axis detector with a register port.
// ============================================================================
// An accepted sample passes the second front stage, the queue, the back's job
// register and the output register. The front takes no new sample while one is
// in its second stage (filter sum and state write back) or the queue is full;
// the back delivers one result per cycle while the receiver is ready.
// Reset: synchronous, active low; clears all slot state and loads register
// defaults. No clearing pass is needed.
`default_nettype none

module accel_motion_and_orientation_detector_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Register port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [amod_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // Samples.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // slot[1:0], accel_x[9:2], accel_y[17:10], accel_z[25:18], time_stamp[57:26]
    input  wire logic [amod_pkg::S_DATA_W-1:0] s_tdata,
    // Results.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // slot_out[1:0], stamp_out[33:2], axis_code[36:34], report_x[45:37],
    // report_y[54:46], report_z[62:55]
    output logic [amod_pkg::M_DATA_W-1:0]      m_tdata,
    // event_kind[1:0]
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast
);

    amod_pkg::cfg_t    cfg_reg;
    amod_pkg::job_t    push_job;
    amod_pkg::job_t    head_job;
    logic              push;
    logic              q_full;
    logic              head_valid;
    logic              pop;
    logic              wr_en;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[amod_pkg::ADDR_W-1:2];

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.move_thr     <= 8'd3;
            cfg_reg.start_count  <= 8'd5;
            cfg_reg.stop_count   <= 8'd5;
            cfg_reg.stable_count <= 8'd15;
            cfg_reg.stream_en    <= 1'b0;
            cfg_reg.stream_slot  <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                amod_pkg::REG_MOVE_THR:     cfg_reg.move_thr     <= pwdata[7:0];
                amod_pkg::REG_START_COUNT:  cfg_reg.start_count  <= pwdata[7:0];
                amod_pkg::REG_STOP_COUNT:   cfg_reg.stop_count   <= pwdata[7:0];
                amod_pkg::REG_STABLE_COUNT: cfg_reg.stable_count <= pwdata[7:0];
                amod_pkg::REG_STREAM_EN:    cfg_reg.stream_en    <= pwdata[0];
                amod_pkg::REG_STREAM_SLOT:  cfg_reg.stream_slot  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (reg_idx)
            amod_pkg::REG_MOVE_THR:     prdata = 32'(cfg_reg.move_thr);
            amod_pkg::REG_START_COUNT:  prdata = 32'(cfg_reg.start_count);
            amod_pkg::REG_STOP_COUNT:   prdata = 32'(cfg_reg.stop_count);
            amod_pkg::REG_STABLE_COUNT: prdata = 32'(cfg_reg.stable_count);
            amod_pkg::REG_STREAM_EN:    prdata = 32'(cfg_reg.stream_en);
            amod_pkg::REG_STREAM_SLOT:  prdata = 32'(cfg_reg.stream_slot);
            default:                    prdata = '0;
        endcase
    end

    amod_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    amod_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    amod_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (head_valid),
        .q_job    (head_job),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/amod_checker.sv =====
// ============================================================================
// amod_checker
// Port-level checks of the detector, attached to the top level by bind.
// ============================================================================
`default_nettype none

module amod_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        pready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // Reset empties the result channel.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // Stop and stream results carry no axis.
    a_no_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == amod_pkg::EV_STOPPED || m_tuser == amod_pkg::EV_STREAM)
        |-> m_tdata[36:34] == amod_pkg::AXIS_UNKNOWN)
        else $error("axis code on stop or stream result");

    // A stream result always closes its sample's run.
    a_stream_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == amod_pkg::EV_STREAM |-> m_tlast)
        else $error("stream result not last");

    // Register port never waits.
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind accel_motion_and_orientation_detector_unit amod_checker u_amod_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .pready   (pready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/accel_motion_and_orientation_detector_unit_tb.sv =====
// ============================================================================
// accel_motion_and_orientation_detector_unit_tb
// Self-checking testbench. It drives accelerometer samples on the input
// stream with random idle cycles and stalls, and it writes the registers over
// the APB port between phases. An in-bench model of the per-slot filter, the
// motion hysteresis and the up-axis debounce predicts every result
// transaction, and each received transaction is compared field by field.
// ============================================================================
`default_nettype none

module accel_motion_and_orientation_detector_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import amod_pkg::*;

    localparam longint FILT_ONE  = 64'sd65536;
    localparam longint FILT_GAIN = FILT_ONE / 10;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     SETTLE_CYCLES = 20;

    // One expected result transaction.
    typedef struct {
        event_kind_t      kind;
        logic [1:0]       slot;
        logic [31:0]      stamp;
        logic [2:0]       axis;
        logic [8:0]       rep_x;
        logic [8:0]       rep_y;
        logic [7:0]       rep_z;
        logic             last;
    } detect_event_t;

    // One row of the directed sample table; n_events < 0 means not typed in.
    typedef struct {
        logic [1:0]  slot;
        int          ax;
        int          ay;
        int          az;
        logic [31:0] stamp;
        int          n_events;
    } sample_row_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Model state of every slot.
    longint      filt_acc [SLOT_COUNT][3];
    int          motion_cnt [SLOT_COUNT];
    bit          is_moving [SLOT_COUNT];
    logic [2:0]  motion_dir [SLOT_COUNT];
    logic [2:0]  up_reported [SLOT_COUNT];
    logic [2:0]  up_candidate [SLOT_COUNT];
    int          up_cand_cnt [SLOT_COUNT];

    // Model copy of the registers.
    int          thr_move;
    int          cnt_start;
    int          cnt_stop;
    int          cnt_stable;
    bit          strm_en;
    logic [1:0]  strm_slot;

    detect_event_t pending_events [$];
    int          snd_idle_pct;
    int          rcv_idle_pct;
    int          mismatch_cnt;
    int          cycle_cnt;
    int          last_predicted;

    accel_motion_and_orientation_detector_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock.
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Run limit.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver stalls.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    function automatic int abs_val(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Clear the model to its reset state.
    task automatic model_reset();
        for (int s = 0; s < SLOT_COUNT; s++) begin
            for (int k = 0; k < 3; k++) filt_acc[s][k] = 0;
            motion_cnt[s]   = 0;
            is_moving[s]    = 0;
            motion_dir[s]   = AXIS_UNKNOWN;
            up_reported[s]  = AXIS_UNKNOWN;
            up_candidate[s] = AXIS_UNKNOWN;
            up_cand_cnt[s]  = 0;
        end
        thr_move   = 3;
        cnt_start  = 5;
        cnt_stop   = 5;
        cnt_stable = 15;
        strm_en    = 0;
        strm_slot  = 0;
    endtask

    // Work out the events caused by one sample and queue them.
    task automatic predict_events(input logic [1:0] s, input int ax, input int ay,
                                  input int az, input logic [31:0] stamp);
        int            acc [3];
        longint        d;
        longint        v;
        int            max_mag;
        logic [2:0]    dir;
        bit            motion_now;
        bit            hold_filt;
        bit            dir_changed;
        detect_event_t ev;
        detect_event_t evs [$];
        acc[0] = ax;
        acc[1] = ay;
        acc[2] = az;
        motion_now = 0;
        hold_filt = 0;
        max_mag = 0;
        dir = AXIS_UNKNOWN;
        ev.slot = s;
        ev.stamp = stamp;
        ev.last = 0;

        // Motion evidence on any axis.
        for (int k = 0; k < 3; k++) begin
            d = (filt_acc[s][k] >>> FRAC_BITS) - acc[k];
            if (abs_val(d) >= thr_move) motion_now = 1;
        end

        // Hysteresis counter.
        if (motion_now) begin
            hold_filt = !is_moving[s] && motion_cnt[s] <= 1;
            if ((!is_moving[s] || motion_cnt[s] < cnt_stop) && motion_cnt[s] < 255)
                motion_cnt[s]++;
        end else if (motion_cnt[s] > 0) begin
            motion_cnt[s]--;
        end

        // Low-pass filter update.
        if (!hold_filt) begin
            for (int k = 0; k < 3; k++)
                filt_acc[s][k] = FILT_GAIN * acc[k]
                               + (((FILT_ONE - FILT_GAIN) * filt_acc[s][k]) >>> FRAC_BITS);
        end

        // Dominant axis of the filtered vector.
        for (int k = 0; k < 3; k++) begin
            v = filt_acc[s][k] >>> FRAC_BITS;
            if (abs_val(v) > max_mag) begin
                dir = (v > 0) ? DIR_POS[k] : DIR_NEG[k];
                max_mag = abs_val(v);
            end
        end
        dir_changed = motion_dir[s] != AXIS_UNKNOWN && motion_dir[s] != dir;
        motion_dir[s] = dir;

        // Up-axis debounce.
        if (dir == up_candidate[s]) begin
            if (up_candidate[s] != up_reported[s]) begin
                if (up_cand_cnt[s] < 255) up_cand_cnt[s]++;
                if (up_cand_cnt[s] >= cnt_stable) begin
                    ev.kind = EV_UPAXIS; ev.axis = up_candidate[s];
                    ev.rep_x = 0; ev.rep_y = 0; ev.rep_z = 0;
                    evs.push_back(ev);
                    up_reported[s] = up_candidate[s];
                end
            end else begin
                up_cand_cnt[s] = 0;
            end
        end else begin
            up_cand_cnt[s] = 0;
            up_candidate[s] = dir;
        end

        // Start, direction change or stop.
        if (dir_changed || (motion_cnt[s] >= cnt_start && !is_moving[s])) begin
            ev.kind = EV_MOVED; ev.axis = dir;
            ev.rep_x = 9'(-az); ev.rep_y = 9'(-ax); ev.rep_z = 8'(ay);
            evs.push_back(ev);
            is_moving[s] = 1;
            motion_cnt[s] = cnt_stop;
        end else if (motion_cnt[s] == 0 && is_moving[s]) begin
            if (up_candidate[s] != up_reported[s]) begin
                ev.kind = EV_UPAXIS; ev.axis = up_candidate[s];
                ev.rep_x = 0; ev.rep_y = 0; ev.rep_z = 0;
                evs.push_back(ev);
                up_reported[s] = up_candidate[s];
            end
            ev.kind = EV_STOPPED; ev.axis = AXIS_UNKNOWN;
            ev.rep_x = 0; ev.rep_y = 0; ev.rep_z = 0;
            evs.push_back(ev);
            is_moving[s] = 0;
        end

        // Raw sample stream.
        if (strm_en && strm_slot == s) begin
            ev.kind = EV_STREAM; ev.axis = AXIS_UNKNOWN;
            ev.rep_x = 9'(-az); ev.rep_y = 9'(-ax); ev.rep_z = 8'(ay);
            evs.push_back(ev);
        end

        if (evs.size() > 0) evs[evs.size() - 1].last = 1;
        last_predicted = evs.size();
        foreach (evs[i]) pending_events.push_back(evs[i]);
    endtask

    task automatic report_mismatch(input string what, input longint exp_v,
                                   input longint got_v);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, exp_v, got_v);
    endtask

    // Result checker.
    always @(posedge aclk) begin
        detect_event_t ev;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected transaction", 0, m_tdata);
            end else begin
                ev = pending_events.pop_front();
                if (m_tuser != ev.kind) report_mismatch("event_kind", ev.kind, m_tuser);
                if (m_tdata[1:0] != ev.slot) report_mismatch("slot", ev.slot, m_tdata[1:0]);
                if (m_tdata[33:2] != ev.stamp)
                    report_mismatch("stamp", ev.stamp, m_tdata[33:2]);
                if (m_tdata[36:34] != ev.axis)
                    report_mismatch("axis_code", ev.axis, m_tdata[36:34]);
                if (m_tdata[45:37] != ev.rep_x)
                    report_mismatch("report_x", ev.rep_x, m_tdata[45:37]);
                if (m_tdata[54:46] != ev.rep_y)
                    report_mismatch("report_y", ev.rep_y, m_tdata[54:46]);
                if (m_tdata[62:55] != ev.rep_z)
                    report_mismatch("report_z", ev.rep_z, m_tdata[62:55]);
                if (m_tlast != ev.last) report_mismatch("last", ev.last, m_tlast);
            end
        end
    end

    // Register write over APB: setup cycle, then access cycle.
    task automatic reg_write(input reg_index_t idx, input int value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_MOVE_THR:     thr_move   = value & 8'hFF;
            REG_START_COUNT:  cnt_start  = value & 8'hFF;
            REG_STOP_COUNT:   cnt_stop   = value & 8'hFF;
            REG_STABLE_COUNT: cnt_stable = value & 8'hFF;
            REG_STREAM_EN:    strm_en    = value & 1;
            REG_STREAM_SLOT:  strm_slot  = value & 3;
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all_regs(input int thr, input int start, input int stop,
                                  input int stable, input int en, input int slot);
        reg_write(REG_MOVE_THR, thr);
        reg_write(REG_START_COUNT, start);
        reg_write(REG_STOP_COUNT, stop);
        reg_write(REG_STABLE_COUNT, stable);
        reg_write(REG_STREAM_EN, en);
        reg_write(REG_STREAM_SLOT, slot);
    endtask

    // Wait until every expected result has arrived, then let the pipe settle.
    task automatic wait_drained();
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Send one sample; called at a falling edge, returns at a falling edge.
    task automatic send_sample(input logic [1:0] s, input int ax, input int ay,
                               input int az, input logic [31:0] stamp);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, stamp, 8'(az), 8'(ay), 8'(ax), s};
        do @(posedge aclk); while (!s_tready);
        predict_events(s, ax, ay, az, stamp);
        @(negedge aclk);
    endtask

    function automatic int clamp8(input int v);
        return (v > 127) ? 127 : (v < -128) ? -128 : v;
    endfunction

    function automatic int rand_axis();
        case ($urandom_range(3))
            0: return -128;
            1: return 127;
            default: return int'($urandom_range(255)) - 128;
        endcase
    endfunction

    // Runs of near-steady samples per slot, with jumps and orientation shifts.
    task automatic send_random(input int count);
        int          sent;
        int          run_len;
        logic [1:0]  s;
        int          bx, by, bz;
        logic [31:0] stamp;
        sent = 0;
        stamp = $urandom;
        while (sent < count) begin
            s = $urandom_range(3);
            bx = rand_axis(); by = rand_axis(); bz = rand_axis();
            run_len = $urandom_range(4, 25);
            for (int i = 0; i < run_len && sent < count; i++) begin
                stamp = ($urandom_range(15) == 0) ? $urandom : stamp + $urandom_range(1, 50);
                if ($urandom_range(7) == 0) begin
                    send_sample(s, rand_axis(), rand_axis(), rand_axis(), stamp);
                end else begin
                    if ($urandom_range(11) == 0) begin
                        bx = rand_axis(); by = rand_axis(); bz = rand_axis();
                    end
                    send_sample(s, clamp8(bx + int'($urandom_range(4)) - 2),
                                clamp8(by + int'($urandom_range(4)) - 2),
                                clamp8(bz + int'($urandom_range(4)) - 2), stamp);
                end
                sent++;
            end
        end
    endtask

    // Directed samples under the reset register values.
    sample_row_t directed_rows [] = '{
        '{2'd0,  127,  127,  127, 32'h0000_0000,  0},
        '{2'd0,  127,  127,  127, 32'hFFFF_FFFF,  0},
        '{2'd0,  127,  127,  127, 32'h0000_0002, -1},
        '{2'd0,  127,  127,  127, 32'h0000_0003, -1},
        '{2'd0,  127,  127,  127, 32'h0000_0004, -1},
        '{2'd0,  127,  127,  127, 32'h0000_0005, -1},
        '{2'd0,  127,  127,  127, 32'h0000_0006, -1},
        '{2'd1, -128, -128, -128, 32'h8000_0000,  0},
        '{2'd1, -128, -128, -128, 32'h7FFF_FFFF,  0},
        '{2'd1, -128, -128, -128, 32'h0000_0010, -1},
        '{2'd1, -128, -128, -128, 32'h0000_0011, -1},
        '{2'd1, -128, -128, -128, 32'h0000_0012, -1},
        '{2'd1, -128, -128, -128, 32'h0000_0013, -1},
        '{2'd2,    0,    0,    0, 32'h5555_5555,  0},
        '{2'd2,    0,    0,    0, 32'hAAAA_AAAA,  0},
        '{2'd3,   -1,    0,    1, 32'h0000_0020,  0},
        '{2'd3,  127, -128,    0, 32'h0000_0021, -1},
        '{2'd3,    0,  127, -128, 32'h0000_0022, -1},
        '{2'd3, -128,    0,  127, 32'h0000_0023, -1},
        '{2'd0,    0,    0,    0, 32'h0000_0030, -1},
        '{2'd0,    0,    0,    0, 32'h0000_0031, -1},
        '{2'd0,    0,    0,    0, 32'h0000_0032, -1}
    };

    // Main sequence.
    initial begin
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        mismatch_cnt = 0;
        snd_idle_pct = 15;
        rcv_idle_pct = 50;
        model_reset();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, reset register values.
        foreach (directed_rows[i]) begin
            send_sample(directed_rows[i].slot, directed_rows[i].ax, directed_rows[i].ay,
                        directed_rows[i].az, directed_rows[i].stamp);
            if (directed_rows[i].n_events >= 0 && last_predicted != directed_rows[i].n_events)
                report_mismatch("directed event count", directed_rows[i].n_events,
                                last_predicted);
        end
        s_tvalid <= 1'b0;
        wait_drained();

        // Lowest counts, streaming the top slot.
        write_all_regs(1, 1, 1, 1, 1, 3);
        @(negedge aclk);
        send_random(150);
        s_tvalid <= 1'b0;
        wait_drained();

        // Highest counts and threshold, streaming slot 0.
        snd_idle_pct = 50;
        rcv_idle_pct = 15;
        write_all_regs(255, 255, 255, 255, 1, 0);
        @(negedge aclk);
        send_random(150);
        s_tvalid <= 1'b0;
        wait_drained();

        // Mid-range values, no idling; one full drain in the middle.
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_all_regs($urandom_range(0, 6), $urandom_range(2, 6), $urandom_range(1, 8),
                       $urandom_range(2, 20), $urandom_range(1), $urandom_range(3));
        @(negedge aclk);
        send_random(70);
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(negedge aclk);
        send_random(70);
        s_tvalid <= 1'b0;
        wait_drained();

        if (mismatch_cnt == 0 && pending_events.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
